FILE: rtl/taylor_elementary_function_unit_core_defines.svh
// ---------------------------------------------------------------------------
// Taylor elementary function unit: assertion macros
// Shared concurrent assertion forms, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef TAYLOR_ELEMENTARY_FUNCTION_UNIT_CORE_DEFINES_SVH
`define TAYLOR_ELEMENTARY_FUNCTION_UNIT_CORE_DEFINES_SVH

`ifndef SYNTH
// Same-cycle implication, checked at every rising edge outside reset.
`define TEFU_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tefu assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define TEFU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tefu assertion failed");
`else
`define TEFU_ASSERT_IMPL(lbl, ante, cons)
`define TEFU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: rtl/tefu_pkg.sv
// ---------------------------------------------------------------------------
// Taylor elementary function unit: package
// Types, widths and constants shared by the term stages and the top level.
// ---------------------------------------------------------------------------
package tefu_pkg;

  localparam int CNT_W         = 5;   // holds a term count up to 17
  localparam int MAG_W         = 34;  // magnitude of the series multiplicand
  localparam int DIV_W         = 11;  // largest term divisor is 33*32
  localparam int VAL_W         = 56;  // Q27.28 result width
  localparam int DEF_MAX_TERMS = 8;

  localparam logic signed [31:0] TWO_PI = 32'sd1686629713;
  localparam logic [55:0]        Q_ONE  = 56'd268435456;

  // Index of the only configuration register.
  localparam logic REG_TERM_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_EXP = 2'd0,
    OP_SIN = 2'd1,
    OP_COS = 2'd2,
    OP_LN  = 2'd3
  } op_t;

  // State of one evaluation between term stages.
  typedef struct packed {
    op_t                     op;
    logic [CNT_W-1:0]        cnt;
    logic                    ovf;
    logic signed [VAL_W-1:0] sum;
    logic [VAL_W-1:0]        cmag;  // running term magnitude
    logic                    csgn;
    logic [MAG_W-1:0]        mmag;  // fixed multiplicand magnitude
    logic                    msgn;
  } item_t;

endpackage

FILE: rtl/tefu_in_if.sv
// ---------------------------------------------------------------------------
// Taylor elementary function unit: operand channel
// Valid/ready channel carrying the opcode and the Q3.28 argument.
// ---------------------------------------------------------------------------
interface tefu_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [31:0] argument;

  modport source (output valid, output opcode, output argument, input ready);
  modport sink (input valid, input opcode, input argument, output ready);
endinterface

FILE: rtl/tefu_out_if.sv
// ---------------------------------------------------------------------------
// Taylor elementary function unit: result channel
// Valid/ready channel carrying the Q27.28 sum and the overflow flag.
// ---------------------------------------------------------------------------
interface tefu_out_if;
  logic               valid;
  logic               ready;
  logic signed [55:0] value;
  logic               overflow;

  modport source (output valid, output value, output overflow, input ready);
  modport sink (input valid, input value, input overflow, output ready);
endinterface

FILE: rtl/taylor_elementary_function_unit_core.sv
// ---------------------------------------------------------------------------
// Taylor elementary function unit core
// Pipelined truncated Taylor series for exp, sine, cosine and natural log.
// ---------------------------------------------------------------------------
// The core takes one operand transaction per clock cycle while the pipeline
// advances, and returns one result transaction for each, in order. Every
// evaluation runs through a fixed pipeline of 5 + 7*MAX_TERMS register
// stages: five front stages reduce the argument, square it and set up the
// series, and each of the MAX_TERMS term units spends seven stages on one
// product, one constant division and one accumulation. The
// whole pipeline moves forward whenever the result register is empty or is
// being read, so a transaction that is waiting on the result side holds the
// pipeline in place and nothing is lost or repeated. term_count is read as
// the operand enters and is meant to be written only while the core is idle;
// zero acts as one and values above MAX_TERMS act as MAX_TERMS. All
// arithmetic is signed fixed point in Q.28; intermediate products and sums
// that leave the Q27.28 range are clamped and raise the overflow flag.

`include "taylor_elementary_function_unit_core_defines.svh"

module taylor_elementary_function_unit_core #(
  parameter int MAX_TERMS = tefu_pkg::DEF_MAX_TERMS
) (
  input  logic        clk,
  input  logic        rst,
  tefu_in_if.sink     operand,
  tefu_out_if.source  result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tefu_pkg::*;

  // The pipeline advances as a whole when the result register can move.
  logic adv;

  // Configuration register.
  logic [3:0] term_count;
  logic       cfg_wr;

  // Front stages.
  logic vA, vB, vC, vD, vE;

  op_t              opA, opB, opC, opD;
  logic [CNT_W-1:0] cntA, cntB, cntC, cntD;
  logic signed [31:0] xA, xB;
  logic signed [32:0] rB, dB;
  logic [31:0] xmagC, xmagD;
  logic        xsgnC, xsgnD;
  logic [30:0] rmagC, rmagD;
  logic        rsgnC, rsgnD;
  logic [31:0] dmagC, dmagD;
  logic        dsgnC, dsgnD;
  logic [61:0] sqD;

  logic [CNT_W-1:0] cnt_eff;
  logic signed [32:0] xw;

  item_t init_item;

  logic  [MAX_TERMS:0] cvld;
  item_t               citem [MAX_TERMS+1];

  assign adv           = ~result.valid | result.ready;
  assign operand.ready = adv;

  // APB register access. The register is decoded from paddr[2] alone; writes
  // with paddr[2] set are dropped and reads with paddr[2] set return zero.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_TERM_COUNT);
  assign prdata = (paddr[2] == REG_TERM_COUNT) ? {28'd0, term_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      term_count <= 4'd8;
    end else if (cfg_wr) begin
      term_count <= pwdata[3:0];
    end
  end

  // Effective term count, clamped to one through MAX_TERMS.
  always_comb begin
    priority if (term_count == 4'd0) begin
      cnt_eff = CNT_W'(1);
    end else if (CNT_W'(term_count) > CNT_W'(MAX_TERMS)) begin
      cnt_eff = CNT_W'(MAX_TERMS);
    end else begin
      cnt_eff = CNT_W'(term_count);
    end
  end

  assign xw = {xA[31], xA};

  // Series start values for each function. The sine and cosine multiplicand
  // is the squared reduced argument, which always stays below 40 in Q.28.
  always_comb begin
    init_item.op   = opD;
    init_item.cnt  = cntD;
    init_item.ovf  = 1'b0;
    init_item.mmag = sqD[61:28];
    init_item.msgn = 1'b0;
    init_item.sum  = $signed(Q_ONE);
    init_item.cmag = Q_ONE;
    init_item.csgn = 1'b0;
    unique case (opD)
      OP_EXP: begin
        init_item.mmag = MAG_W'(xmagD);
        init_item.msgn = xsgnD;
      end
      OP_SIN: begin
        init_item.sum  = rsgnD ? -$signed(VAL_W'(rmagD)) : $signed(VAL_W'(rmagD));
        init_item.cmag = VAL_W'(rmagD);
        init_item.csgn = rsgnD;
      end
      OP_COS: begin
        init_item.cmag = Q_ONE;
      end
      OP_LN: begin
        init_item.sum  = dsgnD ? -$signed(VAL_W'(dmagD)) : $signed(VAL_W'(dmagD));
        init_item.cmag = VAL_W'(dmagD);
        init_item.csgn = dsgnD;
        init_item.mmag = MAG_W'(dmagD);
        init_item.msgn = dsgnD;
      end
      default: begin
        init_item.cmag = Q_ONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vA <= 1'b0;
      vB <= 1'b0;
      vC <= 1'b0;
      vD <= 1'b0;
      vE <= 1'b0;
    end else if (adv) begin
      vA <= operand.valid;
      vB <= vA;
      vC <= vB;
      vD <= vC;
      vE <= vD;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage A: capture the transaction and the clamped term count.
      opA  <= op_t'(operand.opcode);
      xA   <= operand.argument;
      cntA <= cnt_eff;

      // Stage B: one step of range reduction by 2*pi, and x - 1 for ln.
      opB  <= opA;
      cntB <= cntA;
      xB   <= xA;
      priority if (xA >= TWO_PI) begin
        rB <= xw - 33'(TWO_PI);
      end else if (xA <= -TWO_PI) begin
        rB <= xw + 33'(TWO_PI);
      end else begin
        rB <= xw;
      end
      dB <= xw - 33'sd268435456;

      // Stage C: split into sign and magnitude.
      opC   <= opB;
      cntC  <= cntB;
      xsgnC <= xB[31];
      xmagC <= xB[31] ? 32'(-{xB[31], xB}) : 32'(xB);
      rsgnC <= rB[32];
      rmagC <= rB[32] ? 31'(-rB) : 31'(rB);
      dsgnC <= dB[32];
      dmagC <= dB[32] ? 32'(-dB) : 32'(dB);

      // Stage D: square of the reduced argument.
      opD   <= opC;
      cntD  <= cntC;
      xsgnD <= xsgnC;
      xmagD <= xmagC;
      rsgnD <= rsgnC;
      rmagD <= rmagC;
      dsgnD <= dsgnC;
      dmagD <= dmagC;
      sqD   <= 62'(rmagC) * 62'(rmagC);

      // Stage E: start values of the series.
      citem[0] <= init_item;
    end
  end

  assign cvld[0] = vE;

  for (genvar j = 1; j <= MAX_TERMS; j++) begin : g_term
    tefu_term #(
      .STAGE (j)
    ) u_term (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_vld   (cvld[j-1]),
      .in_item  (citem[j-1]),
      .out_vld  (cvld[j]),
      .out_item (citem[j])
    );
  end

  // The last term stage is the result register.
  assign result.valid    = cvld[MAX_TERMS];
  assign result.value    = citem[MAX_TERMS].sum;
  assign result.overflow = citem[MAX_TERMS].ovf;

  `TEFU_ASSERT_IMPL(a_ready_when_empty, !result.valid, operand.ready)
  `TEFU_ASSERT_NEXT(a_cfg_write, cfg_wr, term_count == $past(pwdata[3:0]))
  `TEFU_ASSERT_IMPL(a_cnt_range, vA, (cntA != '0) && (cntA <= CNT_W'(MAX_TERMS)))

endmodule

FILE: rtl/tefu_term.sv
// ---------------------------------------------------------------------------
// Taylor elementary function unit: one series term
// Seven-stage pipeline: Q.28 product with saturation, division by the
// term's constant divisor through a reciprocal, then the saturating add.
// ---------------------------------------------------------------------------
module tefu_term #(
  parameter int STAGE = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_vld,
  input  tefu_pkg::item_t in_item,
  output logic           out_vld,
  output tefu_pkg::item_t out_item
);
  import tefu_pkg::*;

  localparam int DIV_EXP = STAGE;
  localparam int DIV_SIN = (2 * STAGE + 1) * (2 * STAGE);
  localparam int DIV_COS = (2 * STAGE) * (2 * STAGE - 1);
  localparam int DIV_LN  = STAGE + 1;

  localparam logic [56:0] REC_ONE = 57'd1 << 56;
  localparam logic [56:0] REC_EXP = REC_ONE / 57'(DIV_EXP);
  localparam logic [56:0] REC_SIN = REC_ONE / 57'(DIV_SIN);
  localparam logic [56:0] REC_COS = REC_ONE / 57'(DIV_COS);
  localparam logic [56:0] REC_LN  = REC_ONE / 57'(DIV_LN);

  // For ln the divisor is k = STAGE + 1, and even k subtracts.
  localparam logic LN_SUB = ((STAGE % 2) == 1);

  localparam logic [55:0] MAG_POS = (56'd1 << 55) - 56'd1;
  localparam logic [55:0] MAG_NEG = 56'd1 << 55;

  localparam logic signed [57:0] SUM_MAX = (58'sd1 <<< 55) - 58'sd1;
  localparam logic signed [57:0] SUM_MIN = -(58'sd1 <<< 55);

  logic [7:1] vld;

  item_t it1, it2, it3, it4, it5, it6;
  item_t it3_next;
  item_t out_next;

  logic [55:0] p0, p2;
  logic [33:0] p1, p3;
  logic [89:0] prod;

  logic [55:0]      pm3, pm4, pm5, pm6;
  logic             ps3, ps4, ps5, ps6;
  logic             act3, act4, act5, act6;
  logic [DIV_W-1:0] dv3, dv4, dv5;
  logic [56:0]      rc3;
  logic [55:0]      q0, q2;
  logic [56:0]      q1, q3;
  logic [55:0]      qe5;
  logic [55:0]      qm6;

  // Stage 3 product scaling and saturation.
  logic [61:0] sh;
  logic        ps;
  logic [55:0] lim;
  logic        sat3;
  logic        act;

  // Stage 5 and 6 quotient correction.
  logic [112:0] qsum;
  logic [66:0]  qd;
  logic [66:0]  rem;

  // Stage 7 accumulation.
  logic               asgn;
  logic signed [57:0] tv;
  logic signed [57:0] acc;
  logic signed [55:0] acc_sat;
  logic               sat7;

  always_comb begin
    sh   = prod[89:28];
    ps   = it2.csgn ^ it2.msgn;
    lim  = ps ? MAG_NEG : MAG_POS;
    sat3 = (sh > 62'(lim));
    if ((it2.op == OP_EXP) || (it2.op == OP_COS)) begin
      act = (it2.cnt >= CNT_W'(STAGE));
    end else begin
      act = (it2.cnt >= CNT_W'(STAGE + 1));
    end
    it3_next     = it2;
    it3_next.ovf = it2.ovf | (act & sat3);
  end

  always_comb begin
    qsum = 113'(q0) + (113'(q1) << 28) + (113'(q2) << 28) + (113'(q3) << 56);
    qd   = 67'(qe5) * 67'(dv5);
    rem  = 67'(pm5) - qd;
  end

  always_comb begin
    unique case (it6.op)
      OP_EXP:  asgn = ps6;
      OP_SIN:  asgn = ~ps6;
      OP_COS:  asgn = ~ps6;
      OP_LN:   asgn = ps6 ^ LN_SUB;
      default: asgn = ps6;
    endcase
    tv  = asgn ? -$signed({2'b00, qm6}) : $signed({2'b00, qm6});
    acc = 58'(it6.sum) + tv;
    sat7 = 1'b0;
    if (acc > SUM_MAX) begin
      acc_sat = SUM_MAX[55:0];
      sat7    = 1'b1;
    end else if (acc < SUM_MIN) begin
      acc_sat = SUM_MIN[55:0];
      sat7    = 1'b1;
    end else begin
      acc_sat = acc[55:0];
    end
  end

  // Accumulate, and pick the value carried to the next term.
  always_comb begin
    out_next = it6;
    if (act6) begin
      out_next.sum = acc_sat;
      out_next.ovf = it6.ovf | sat7;
      if (it6.op == OP_LN) begin
        out_next.cmag = pm6;
        out_next.csgn = ps6;
      end else begin
        out_next.cmag = qm6;
        out_next.csgn = asgn;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[6:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // Stage 1: partial products of the two magnitudes.
      it1 <= in_item;
      p0  <= 56'(in_item.cmag[27:0]) * 56'(in_item.mmag[27:0]);
      p1  <= 34'(in_item.cmag[27:0]) * 34'(in_item.mmag[33:28]);
      p2  <= 56'(in_item.cmag[55:28]) * 56'(in_item.mmag[27:0]);
      p3  <= 34'(in_item.cmag[55:28]) * 34'(in_item.mmag[33:28]);

      // Stage 2: full product.
      it2  <= it1;
      prod <= 90'(p0) + (90'(p1) << 28) + (90'(p2) << 28) + (90'(p3) << 56);

      // Stage 3: Q.28 scaling with saturation, divisor selection.
      it3      <= it3_next;
      pm3      <= sat3 ? lim : sh[55:0];
      ps3      <= ps;
      act3     <= act;
      unique case (it2.op)
        OP_EXP: begin
          dv3 <= DIV_W'(DIV_EXP);
          rc3 <= REC_EXP;
        end
        OP_SIN: begin
          dv3 <= DIV_W'(DIV_SIN);
          rc3 <= REC_SIN;
        end
        OP_COS: begin
          dv3 <= DIV_W'(DIV_COS);
          rc3 <= REC_COS;
        end
        OP_LN: begin
          dv3 <= DIV_W'(DIV_LN);
          rc3 <= REC_LN;
        end
        default: begin
          dv3 <= DIV_W'(DIV_EXP);
          rc3 <= REC_EXP;
        end
      endcase

      // Stage 4: partial products of magnitude and reciprocal.
      it4  <= it3;
      pm4  <= pm3;
      ps4  <= ps3;
      act4 <= act3;
      dv4  <= dv3;
      q0   <= 56'(pm3[27:0]) * 56'(rc3[27:0]);
      q1   <= 57'(pm3[27:0]) * 57'(rc3[56:28]);
      q2   <= 56'(pm3[55:28]) * 56'(rc3[27:0]);
      q3   <= 57'(pm3[55:28]) * 57'(rc3[56:28]);

      // Stage 5: quotient estimate, low by at most one.
      it5  <= it4;
      pm5  <= pm4;
      ps5  <= ps4;
      act5 <= act4;
      dv5  <= dv4;
      qe5  <= qsum[111:56];

      // Stage 6: remainder check and correction.
      it6  <= it5;
      pm6  <= pm5;
      ps6  <= ps5;
      act6 <= act5;
      qm6  <= (rem >= 67'(dv5)) ? qe5 + 56'd1 : qe5;

      // Stage 7: the updated sum and the value carried to the next term.
      out_item <= out_next;
    end
  end

  assign out_vld = vld[7];

endmodule

FILE: tb/tb.sv
// ---------------------------------------------------------------------------
// Taylor elementary function unit core testbench
// Drives operand transactions through the core under changing term counts,
// predicts or looks up each sum and overflow flag, and checks every result.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tefu_pkg::*;

  localparam longint SUM_MAX = (64'sd1 <<< 55) - 1;
  localparam longint SUM_MIN = -(64'sd1 <<< 55);
  localparam longint ONE_Q   = 64'sd268435456;
  localparam int     TERMS_LIMIT = 8;
  localparam int     DRAIN_CYCLES = 80;        // pipeline is 61 stages deep
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     PHASE_ITEMS  = 125;
  localparam int     HOLD_CYCLES  = 300;       // long stall on the result side
  localparam logic [2:0] ADDR_TERM_COUNT = 3'd0;
  localparam logic [2:0] ADDR_UNUSED     = 3'd4;

  typedef struct {
    logic signed [55:0] value;
    logic               overflow;
  } series_result_t;

  // One row of the directed stimulus. When known is set, the expected sum
  // is typed in; otherwise it comes from the series predictor.
  typedef struct {
    int                 terms;
    op_t                op;
    logic signed [31:0] arg;
    bit                 known;
    longint             value;
    bit                 overflow;
  } directed_row_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tefu_in_if  opnd ();
  tefu_out_if res ();

  taylor_elementary_function_unit_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .operand (opnd),
    .result  (res),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Expected sums in arrival order, and the predictor's copy of term_count.
  series_result_t pending_sums[$];
  logic [3:0]     terms_reg;
  int             errors;
  int             cycles;
  bit             calm;        // no random idling on either side while set
  bit             hold_req;    // asks the result side for a long stall

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Clamp a value to the Q27.28 range, flagging the overflow.
  function automatic longint clamp_sum(input longint v, inout bit ovf);
    if (v > SUM_MAX) begin
      ovf = 1'b1;
      return SUM_MAX;
    end
    if (v < SUM_MIN) begin
      ovf = 1'b1;
      return SUM_MIN;
    end
    return v;
  endfunction

  // Q.28 product rounded toward zero, then clamped.
  function automatic longint q28_mul(input longint a, input longint b, inout bit ovf);
    logic signed [127:0] wa, wb, prod;
    wa = a;
    wb = b;
    prod = (wa * wb) / 128'sd268435456;
    if (prod > SUM_MAX) begin
      ovf = 1'b1;
      return SUM_MAX;
    end
    if (prod < SUM_MIN) begin
      ovf = 1'b1;
      return SUM_MIN;
    end
    return longint'(prod);
  endfunction

  // Truncated Taylor sum for one operand under the current term count.
  function automatic series_result_t series_sum(input op_t op, input logic signed [31:0] arg);
    series_result_t out;
    longint x, n, s, t, r, r2, d, p, k;
    bit ovf;
    x = arg;
    ovf = 1'b0;
    n = terms_reg;
    if (n < 1) n = 1;
    if (n > TERMS_LIMIT) n = TERMS_LIMIT;
    case (op)
      OP_EXP: begin
        t = ONE_Q;
        s = ONE_Q;
        for (k = 1; k <= n; k++) begin
          t = q28_mul(t, x, ovf) / k;
          s = clamp_sum(s + t, ovf);
        end
      end
      OP_SIN, OP_COS: begin
        // Single-step reduction by 2*pi toward zero.
        r = x;
        if (x >= TWO_PI) r = x - TWO_PI;
        else if (x <= -TWO_PI) r = x + TWO_PI;
        r2 = q28_mul(r, r, ovf);
        if (op == OP_SIN) begin
          t = r;
          s = r;
          for (k = 2; k <= n; k++) begin
            t = -(q28_mul(t, r2, ovf) / ((2 * k - 1) * (2 * k - 2)));
            s = clamp_sum(s + t, ovf);
          end
        end else begin
          t = ONE_Q;
          s = ONE_Q;
          for (k = 1; k <= n; k++) begin
            t = -(q28_mul(t, r2, ovf) / ((2 * k) * (2 * k - 1)));
            s = clamp_sum(s + t, ovf);
          end
        end
      end
      default: begin
        // Natural log: alternating powers of (x - 1) divided by k.
        d = x - ONE_Q;
        p = d;
        s = d;
        for (k = 2; k <= n; k++) begin
          p = q28_mul(p, d, ovf);
          t = p / k;
          s = clamp_sum((k % 2 == 1) ? s + t : s - t, ovf);
        end
      end
    endcase
    out.value = s[55:0];
    out.overflow = ovf;
    return out;
  endfunction

  // Register write: a setup phase, then an access phase. pready is always
  // high, so the write lands at the edge that ends the access phase.
  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_TERM_COUNT) terms_reg = data[3:0];
  endtask

  // Wait until every expected result has come back, then let the pipeline
  // settle before the configuration is touched.
  task automatic drain();
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic int idle_len();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one operand transaction and hold it until it is accepted. The
  // expectation is queued at the accepting edge, ahead of any result that
  // could come from it.
  task automatic send_operand(input op_t op, input logic signed [31:0] arg,
                              input bit known, input series_result_t typed);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      opnd.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    opnd.valid    <= 1'b1;
    opnd.opcode   <= op;
    opnd.argument <= arg;
    do @(posedge clk); while (!opnd.ready);
    pending_sums.push_back(known ? typed : series_sum(op, arg));
  endtask

  // Arguments that mostly sit in each function's useful range, with a share
  // of fully random words so that every bit toggles.
  function automatic logic signed [31:0] pick_arg(input op_t op);
    int roll;
    roll = $urandom_range(99);
    if (roll < 30) return $urandom;
    if (roll < 40) return $urandom_range(2, 0) == 0 ? 32'sh7FFFFFFF
                        : ($urandom_range(1) ? 32'sh80000000 : $urandom_range(255));
    case (op)
      OP_EXP: return $signed($urandom_range(32'h40000000)) - 32'sh20000000;
      OP_SIN, OP_COS: return $signed($urandom_range(32'h7FFFFFFF)) - 32'sh3FFFFFFF;
      default: return $urandom_range(32'h20000000);
    endcase
  endfunction

  // Result side: random stalls, calm stretches, and one long hold-off on
  // request so that the pipeline fills and pushes back on the operand side.
  initial begin
    int gap;
    res.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = idle_len();
      if (gap > 0) begin
        res.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
  end

  // Every accepted result transaction is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    series_result_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_sums.size() == 0) begin
        report($sformatf("unexpected result value=%h", res.value));
      end else begin
        want = pending_sums.pop_front();
        if (res.value !== want.value)
          report($sformatf("value %h, expected %h", res.value, want.value));
        if (res.overflow !== want.overflow)
          report($sformatf("overflow %b, expected %b", res.overflow, want.overflow));
      end
    end
  end

  // Directed stimulus: reset values, the argument extremes, every function,
  // the reduction boundaries, the log outside its convergence range, and
  // the term count at its limits, at zero and above the maximum.
  directed_row_t directed[] = '{
    '{8, OP_EXP, 32'sh00000000, 1, 268435456, 0},
    '{8, OP_SIN, 32'sh00000000, 1, 0, 0},
    '{8, OP_COS, 32'sh00000000, 1, 268435456, 0},
    '{8, OP_LN,  32'sh10000000, 1, 0, 0},
    '{8, OP_EXP, 32'sh7FFFFFFF, 0, 0, 0},
    '{8, OP_EXP, 32'sh80000000, 0, 0, 0},
    '{8, OP_SIN, 32'sd1686629713, 0, 0, 0},
    '{8, OP_SIN, -32'sd1686629713, 0, 0, 0},
    '{8, OP_SIN, 32'sd1686629712, 0, 0, 0},
    '{8, OP_COS, -32'sd1686629712, 0, 0, 0},
    '{8, OP_SIN, 32'sh7FFFFFFF, 0, 0, 0},
    '{8, OP_COS, 32'sh80000000, 0, 0, 0},
    '{8, OP_LN,  32'sh00000000, 0, 0, 0},
    '{8, OP_LN,  32'sh80000000, 0, 0, 0},
    '{8, OP_LN,  32'sh7FFFFFFF, 0, 0, 0},
    '{8, OP_LN,  32'sh20000000, 0, 0, 0},
    '{1, OP_EXP, 32'sh10000000, 1, 536870912, 0},
    '{1, OP_SIN, 32'sh7FFFFFFF, 0, 0, 0},
    '{1, OP_LN,  32'sh80000000, 0, 0, 0},
    '{0, OP_COS, 32'sh10000000, 0, 0, 0},
    '{0, OP_EXP, 32'sh80000000, 0, 0, 0},
    '{15, OP_EXP, 32'sh7FFFFFFF, 0, 0, 0},
    '{15, OP_LN, 32'sh7FFFFFFF, 0, 0, 0},
    '{15, OP_SIN, 32'sh30000000, 0, 0, 0}
  };

  // Term count used in each random phase; the extremes come first.
  int phase_terms[] = '{8, 1, 0, 15, 4, 2, 7, 3, 6, 5};

  initial begin
    series_result_t typed;
    op_t op;
    rst        = 1'b1;
    errors     = 0;
    cycles     = 0;
    calm       = 1'b0;
    hold_req   = 1'b0;
    terms_reg  = 4'd8;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    opnd.valid = 1'b0;
    opnd.opcode = OP_EXP;
    opnd.argument = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A write to an address with no register behind it must change nothing.
    reg_write(ADDR_UNUSED, 32'd3);

    foreach (directed[i]) begin
      if (directed[i].terms != terms_reg) begin
        opnd.valid <= 1'b0;
        drain();
        reg_write(ADDR_TERM_COUNT, directed[i].terms);
      end
      typed.value = directed[i].value[55:0];
      typed.overflow = directed[i].overflow;
      send_operand(directed[i].op, directed[i].arg, directed[i].known, typed);
    end

    foreach (phase_terms[ph]) begin
      opnd.valid <= 1'b0;
      drain();
      reg_write(ADDR_TERM_COUNT, (ph == 9) ? $urandom_range(15) : phase_terms[ph]);
      calm = (ph % 3 == 1);
      // The long hold-off happens while the operand side runs flat out.
      if (ph == 4) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        op = op_t'($urandom_range(3));
        send_operand(op, pick_arg(op), 1'b0, typed);
      end
    end
    opnd.valid <= 1'b0;
    calm = 1'b0;

    while (pending_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
